// ===== hw/rtl/ppec_pkg.sv =====
`timescale 1ns / 1ps

package ppec_pkg;

  localparam int MaxProcs   = 64;
  localparam int MaxRecords = 1024;
  localparam int NumCnt     = 9;

  localparam int SlotW  = $clog2(MaxProcs);
  localparam int RecW   = $clog2(MaxRecords);
  localparam int CntAw  = $clog2(MaxProcs * NumCnt);
  localparam int CntIdW = $clog2(NumCnt);

  localparam logic [3:0] CmdAdd    = 4'd0;
  localparam logic [3:0] CmdRemove = 4'd1;
  localparam logic [3:0] CmdAlloc  = 4'd2;
  localparam logic [3:0] CmdFree   = 4'd3;
  localparam logic [3:0] CmdSched  = 4'd4;
  localparam logic [3:0] CmdUnlock = 4'd8;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoId    = 3'd1;
  localparam logic [2:0] StIdFull  = 3'd2;
  localparam logic [2:0] StDupId   = 3'd3;
  localparam logic [2:0] StRecFull = 3'd4;
  localparam logic [2:0] StNoAddr  = 3'd5;

  // counter indexes within a slot
  localparam logic [CntIdW-1:0] CAlloc  = CntIdW'(0);
  localparam logic [CntIdW-1:0] CFree   = CntIdW'(1);
  localparam logic [CntIdW-1:0] CAbytes = CntIdW'(2);
  localparam logic [CntIdW-1:0] CFbytes = CntIdW'(3);
  localparam logic [CntIdW-1:0] CLast   = CntIdW'(NumCnt - 1);

  typedef struct packed {
    logic [3:0]  command;
    logic [21:0] proc_id;
    logic [31:0] mem_addr;
    logic [30:0] mem_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] alloc_count;
    logic [31:0] free_count;
    logic [31:0] alloc_bytes;
    logic [31:0] freed_bytes;
    logic [31:0] sched_count;
    logic [31:0] up_count;
    logic [31:0] down_count;
    logic [31:0] lock_count;
    logic [31:0] unlock_count;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] owner;
    logic [31:0]      addr;
    logic [30:0]      size;
  } rec_t;

endpackage

// ===== hw/rtl/ppec_ram.sv =====
`timescale 1ns / 1ps

module ppec_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/per_process_event_counter_table.sv =====
`timescale 1ns / 1ps
// Channel | Signals                     | Beat
// request | req_valid, req_ready, req   | command, proc_id, mem_addr, mem_size
// result  | rsp_valid, rsp_ready, rsp   | status and nine counters
//
// One item at a time. ID lookup scans every slot of the slot RAM. Remove,
// alloc and free then scan the record RAM entry by entry (alloc/free stop
// at the first hit). Counter read-modify-write then updates the counters
// of the slot. After reset a pass clears the record RAM with req_ready low.
// A waiting result stalls only the final step; the next request is taken
// while the result sits in its register.

module per_process_event_counter_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ppec_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ppec_pkg::rsp_t rsp
);

  typedef enum logic [10:0] {
    S_CLR      = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_SLOT_RD  = 11'b00000000100,
    S_SLOT_CHK = 11'b00000001000,
    S_DISPATCH = 11'b00000010000,
    S_REC_RD   = 11'b00000100000,
    S_REC_CHK  = 11'b00001000000,
    S_CNT_RD   = 11'b00010000000,
    S_CNT_WR   = 11'b00100000000,
    S_ZERO     = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state;

  ppec_pkg::req_t                 cur;
  logic [ppec_pkg::SlotW:0]       slot_i;
  logic [ppec_pkg::RecW:0]        rec_i;
  logic [ppec_pkg::CntIdW-1:0]    j;
  logic                           hit;
  logic                           free_ok;
  logic [ppec_pkg::SlotW-1:0]     hit_slot;
  logic [ppec_pkg::SlotW-1:0]     free_slot;
  logic [ppec_pkg::SlotW-1:0]     cur_slot;
  logic                           rec_ok;
  logic [30:0]                    fbytes;
  logic [2:0]                     status;
  logic [31:0]                    cnt [ppec_pkg::NumCnt];
  logic [ppec_pkg::MaxProcs-1:0]  slot_valid;

  // RAM ports
  logic                           slot_we;
  logic [21:0]                    slot_rdata;
  logic                           rec_we;
  logic [ppec_pkg::RecW-1:0]      rec_waddr;
  ppec_pkg::rec_t                 rec_wdata;
  ppec_pkg::rec_t                 rec_rdata;
  logic                           cnt_we;
  logic [ppec_pkg::CntAw-1:0]     cnt_addr;
  logic [31:0]                    cnt_wdata;
  logic [31:0]                    cnt_rdata;
  logic [31:0]                    cnt_inc;

  logic slot_last, rec_last, rec_match_free, rec_match_own;

  ppec_ram #(.Width(22), .Depth(ppec_pkg::MaxProcs)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (free_slot),
    .wdata (cur.proc_id),
    .raddr (slot_i[ppec_pkg::SlotW-1:0]),
    .rdata (slot_rdata)
  );

  ppec_ram #(.Width($bits(ppec_pkg::rec_t)), .Depth(ppec_pkg::MaxRecords)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_i[ppec_pkg::RecW-1:0]),
    .rdata (rec_rdata)
  );

  ppec_ram #(.Width(32), .Depth(ppec_pkg::MaxProcs * ppec_pkg::NumCnt)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_addr),
    .wdata (cnt_wdata),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign slot_last = (slot_i == (ppec_pkg::SlotW+1)'(ppec_pkg::MaxProcs - 1));
  assign rec_last  = (rec_i == (ppec_pkg::RecW+1)'(ppec_pkg::MaxRecords - 1));
  assign cnt_addr  = ppec_pkg::CntAw'(cur_slot) * ppec_pkg::CntAw'(ppec_pkg::NumCnt)
                   + ppec_pkg::CntAw'(j);

  assign rec_match_own  = rec_rdata.valid && (rec_rdata.owner == cur_slot);
  assign rec_match_free = rec_match_own && (rec_rdata.addr == cur.mem_addr);

  always_comb begin
    cnt_inc = 32'd0;
    case (cur.command)
      ppec_pkg::CmdAlloc: begin
        if (j == ppec_pkg::CAlloc) cnt_inc = 32'd1;
        else if (j == ppec_pkg::CAbytes) cnt_inc = {1'b0, cur.mem_size};
      end
      ppec_pkg::CmdFree: begin
        if (j == ppec_pkg::CFree) cnt_inc = 32'd1;
        else if (j == ppec_pkg::CFbytes && rec_ok) cnt_inc = {1'b0, fbytes};
      end
      default: begin
        // event commands map onto counter index equal to their code
        if (cur.command >= ppec_pkg::CmdSched && cur.command <= ppec_pkg::CmdUnlock &&
            ppec_pkg::CntIdW'(cur.command) == j) begin
          cnt_inc = 32'd1;
        end
      end
    endcase
  end

  always_comb begin
    slot_we   = (state == S_DISPATCH) && (cur.command == ppec_pkg::CmdAdd) && !hit && free_ok;
    rec_we    = 1'b0;
    rec_waddr = rec_i[ppec_pkg::RecW-1:0];
    rec_wdata = '0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rdata + cnt_inc;
    if (state == S_CLR) begin
      rec_we = 1'b1;
    end else if (state == S_REC_CHK) begin
      case (cur.command)
        ppec_pkg::CmdAlloc: begin
          rec_we    = !rec_rdata.valid;
          rec_wdata = '{valid: 1'b1, owner: cur_slot, addr: cur.mem_addr,
                        size: cur.mem_size};
        end
        ppec_pkg::CmdFree: begin
          rec_we    = rec_match_free;
          rec_wdata = rec_rdata;
          rec_wdata.valid = 1'b0;
        end
        default: begin
          rec_we    = rec_match_own;
          rec_wdata = rec_rdata;
          rec_wdata.valid = 1'b0;
        end
      endcase
    end else if (state == S_CNT_WR) begin
      cnt_we = 1'b1;
    end else if (state == S_ZERO) begin
      cnt_we    = 1'b1;
      cnt_wdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      rec_i      <= '0;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // S_DONE drives rsp_valid itself
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          rec_i <= rec_i + 1'b1;
          if (rec_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            slot_i  <= '0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            state   <= S_SLOT_RD;
          end
        end
        S_SLOT_RD: state <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          if (slot_valid[slot_i[ppec_pkg::SlotW-1:0]]) begin
            if (slot_rdata == cur.proc_id && !hit) begin
              hit      <= 1'b1;
              hit_slot <= slot_i[ppec_pkg::SlotW-1:0];
            end
          end else if (!free_ok) begin
            free_ok   <= 1'b1;
            free_slot <= slot_i[ppec_pkg::SlotW-1:0];
          end
          slot_i <= slot_i + 1'b1;
          state  <= slot_last ? S_DISPATCH : S_SLOT_RD;
        end
        S_DISPATCH: begin
          for (int k = 0; k < ppec_pkg::NumCnt; k++) cnt[k] <= 32'd0;
          j        <= '0;
          rec_i    <= '0;
          rec_ok   <= 1'b0;
          cur_slot <= (cur.command == ppec_pkg::CmdAdd && !hit) ? free_slot : hit_slot;
          if (cur.command == ppec_pkg::CmdAdd) begin
            if (hit) begin
              status <= ppec_pkg::StDupId;
              state  <= S_CNT_RD;
            end else if (free_ok) begin
              slot_valid[free_slot] <= 1'b1;
              status   <= ppec_pkg::StOk;
              state    <= S_ZERO;
            end else begin
              status <= ppec_pkg::StIdFull;
              state  <= S_DONE;
            end
          end else if (!hit) begin
            status <= ppec_pkg::StNoId;
            state  <= S_DONE;
          end else begin
            status <= ppec_pkg::StOk;
            case (cur.command)
              ppec_pkg::CmdRemove: begin
                slot_valid[hit_slot] <= 1'b0;
                state <= S_REC_RD;
              end
              ppec_pkg::CmdAlloc, ppec_pkg::CmdFree: state <= S_REC_RD;
              default: state <= S_CNT_RD;
            endcase
          end
        end
        S_REC_RD: state <= S_REC_CHK;
        S_REC_CHK: begin
          rec_i <= rec_i + 1'b1;
          case (cur.command)
            ppec_pkg::CmdAlloc: begin
              if (!rec_rdata.valid || rec_last) begin
                rec_ok <= !rec_rdata.valid;
                status <= rec_rdata.valid ? ppec_pkg::StRecFull : ppec_pkg::StOk;
                state  <= S_CNT_RD;
              end else begin
                state  <= S_REC_RD;
              end
            end
            ppec_pkg::CmdFree: begin
              if (rec_match_free || rec_last) begin
                rec_ok <= rec_match_free;
                fbytes <= rec_rdata.size;
                status <= rec_match_free ? ppec_pkg::StOk : ppec_pkg::StNoAddr;
                state  <= S_CNT_RD;
              end else begin
                state  <= S_REC_RD;
              end
            end
            default: begin
              state <= rec_last ? S_DONE : S_REC_RD;
            end
          endcase
        end
        S_CNT_RD: state <= S_CNT_WR;
        S_CNT_WR: begin
          cnt[j] <= cnt_wdata;
          j      <= j + 1'b1;
          state  <= (j == ppec_pkg::CLast) ? S_DONE : S_CNT_RD;
        end
        S_ZERO: begin
          j     <= j + 1'b1;
          if (j == ppec_pkg::CLast) state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= '{status, cnt[0], cnt[1], cnt[2], cnt[3], cnt[4],
                           cnt[5], cnt[6], cnt[7], cnt[8]};
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/ppec_checker.sv =====
`timescale 1ns / 1ps

module ppec_checker
  import ppec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fails,
  output int   pending
);

  // sched, up, down, lock, unlock follow freed bytes in counter order
  localparam int EvBase = int'(CFbytes) + 1;

  logic              slot_on  [MaxProcs];
  logic [21:0]       slot_pid [MaxProcs];
  logic [31:0]       slot_cnt [MaxProcs][NumCnt];
  logic              rec_on   [MaxRecords];
  int                rec_slot [MaxRecords];
  logic [31:0]       rec_addr [MaxRecords];
  logic [30:0]       rec_size [MaxRecords];

  rsp_t expected_rsps[$];

  function automatic rsp_t apply_cmd(req_t r);
    int s;
    int pick;
    int shown;
    logic [2:0] st;
    logic [31:0] c[NumCnt];
    s = -1;
    pick = -1;
    st = StOk;
    for (int i = 0; i < MaxProcs; i++)
      if (s < 0 && slot_on[i] && slot_pid[i] == r.proc_id) s = i;
    shown = s;
    if (r.command == CmdAdd) begin
      if (s >= 0) begin
        st = StDupId;
      end else begin
        for (int i = 0; i < MaxProcs; i++)
          if (pick < 0 && !slot_on[i]) pick = i;
        if (pick < 0) begin
          st = StIdFull;
        end else begin
          slot_on[pick] = 1'b1;
          slot_pid[pick] = r.proc_id;
          for (int j = 0; j < NumCnt; j++) slot_cnt[pick][j] = '0;
        end
        shown = pick;
      end
    end else if (s < 0) begin
      st = StNoId;
    end else if (r.command == CmdRemove) begin
      for (int i = 0; i < MaxRecords; i++)
        if (rec_on[i] && rec_slot[i] == s) rec_on[i] = 1'b0;
      slot_on[s] = 1'b0;
      shown = -1;
    end else if (r.command == CmdAlloc) begin
      slot_cnt[s][CAlloc] += 1;
      slot_cnt[s][CAbytes] += {1'b0, r.mem_size};
      for (int i = 0; i < MaxRecords; i++)
        if (pick < 0 && !rec_on[i]) pick = i;
      if (pick < 0) begin
        st = StRecFull;
      end else begin
        rec_on[pick] = 1'b1;
        rec_slot[pick] = s;
        rec_addr[pick] = r.mem_addr;
        rec_size[pick] = r.mem_size;
      end
    end else if (r.command == CmdFree) begin
      slot_cnt[s][CFree] += 1;
      for (int i = 0; i < MaxRecords; i++)
        if (pick < 0 && rec_on[i] && rec_slot[i] == s && rec_addr[i] == r.mem_addr) pick = i;
      if (pick < 0) begin
        st = StNoAddr;
      end else begin
        slot_cnt[s][CFbytes] += {1'b0, rec_size[pick]};
        rec_on[pick] = 1'b0;
      end
    end else if (r.command >= CmdSched && r.command <= CmdUnlock) begin
      slot_cnt[s][EvBase + int'(r.command - CmdSched)] += 1;
    end
    for (int j = 0; j < NumCnt; j++) c[j] = (shown >= 0) ? slot_cnt[shown][j] : '0;
    return {st, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
  endfunction

  function automatic logic [31:0] field_of(rsp_t r, int k);
    case (k)
      0: return {29'd0, r.status};
      1: return r.alloc_count;
      2: return r.free_count;
      3: return r.alloc_bytes;
      4: return r.freed_bytes;
      5: return r.sched_count;
      6: return r.up_count;
      7: return r.down_count;
      8: return r.lock_count;
      default: return r.unlock_count;
    endcase
  endfunction

  assign pending = expected_rsps.size();

  initial begin
    fails = 0;
    for (int i = 0; i < MaxProcs; i++) slot_on[i] = 1'b0;
    for (int i = 0; i < MaxRecords; i++) rec_on[i] = 1'b0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat %h", rsp);
        end else begin
          want = expected_rsps.pop_front();
          for (int k = 0; k < 10; k++)
            if (field_of(want, k) !== field_of(rsp, k)) begin
              fails++;
              if (fails <= 10)
                $display("field %0d mismatch: expected %h got %h", k,
                         field_of(want, k), field_of(rsp, k));
            end
        end
      end
      if (req_valid && req_ready) expected_rsps.push_back(apply_cmd(req));
    end
  end

endmodule

// ===== tb/tb_per_process_event_counter_table.sv =====
`timescale 1ns / 1ps

module tb_per_process_event_counter_table;
  import ppec_pkg::*;

  localparam int NumIds   = 80;
  localparam int WdLimit  = 20000;
  localparam int HoldLen  = 3000;

  typedef struct {
    logic [21:0] pid;
    logic [31:0] addr;
  } live_alloc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   fails;
  int   pending;

  int   mode = 0;        // 0: sender 18% idle, rx 83%; 1: swapped; 2: no idling
  bit   hold_req = 1'b0;
  int   quiet = 0;
  logic [21:0] ids[NumIds];
  live_alloc_t live_allocs[$];

  per_process_event_counter_table uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  ppec_checker chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fails(fails), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    int hold_left;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (mode == 0) begin
      rsp_ready <= ($urandom_range(0, 99) >= 83);
    end else if (mode == 1) begin
      rsp_ready <= ($urandom_range(0, 99) >= 18);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WdLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(logic [3:0] cmd, logic [21:0] pid, logic [31:0] addr, logic [30:0] size);
    int pct;
    pct = (mode == 0) ? 18 : (mode == 1) ? 83 : 0;
    if (req_valid && $urandom_range(0, 99) < pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= '{command: cmd, proc_id: pid, mem_addr: addr, mem_size: size};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (cmd == CmdAlloc) live_allocs.push_back('{pid: pid, addr: addr});
  endtask

  task automatic random_beat();
    logic [21:0] pid;
    logic [31:0] addr;
    logic [30:0] size;
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    pid = ids[$urandom_range(0, NumIds - 1)];
    addr = $urandom();
    size = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 4096));
    if (roll < 10) begin
      send(CmdAdd, pid, addr, size);
    end else if (roll < 14) begin
      send(CmdRemove, pid, addr, size);
    end else if (roll < 40) begin
      send(CmdAlloc, pid, addr, size);
      if (live_allocs.size() > 200) void'(live_allocs.pop_front());
    end else if (roll < 65) begin
      if (live_allocs.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, live_allocs.size() - 1);
        pid = live_allocs[k].pid;
        addr = live_allocs[k].addr;
        live_allocs.delete(k);
      end
      send(CmdFree, pid, addr, size);
    end else if (roll < 90) begin
      send(4'($urandom_range(CmdSched, CmdUnlock)), pid, addr, size);
    end else if (roll < 95) begin
      send(4'($urandom_range(9, 15)), pid, addr, size);
    end else begin
      // id almost surely untracked
      send(4'($urandom_range(1, 15)), 22'($urandom()), addr, size);
    end
  endtask

  initial begin
    for (int i = 0; i < NumIds; i++) ids[i] = 22'($urandom());
    ids[0] = '0;
    ids[1] = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    send(4'd9, 22'h3FFFFF, 32'h0, 31'h0);
    send(CmdAdd, 22'h0, 32'h0, 31'h0);
    send(CmdAdd, 22'h3FFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
    send(CmdAdd, 22'h3FFFFF, 32'h0, 31'h0);
    send(CmdAlloc, 22'h0, 32'h0, 31'h0);
    send(CmdAlloc, 22'h3FFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
    send(CmdAlloc, 22'h3FFFFF, 32'hFFFFFFFF, 31'h5);
    send(CmdAlloc, 22'h3FFFFF, 32'h12345678, 31'h7FFFFFFF);
    send(CmdAlloc, 22'h3FFFFF, 32'h12345678, 31'h7FFFFFFF);
    send(CmdFree, 22'h3FFFFF, 32'hFFFFFFFF, 31'h0);
    send(CmdFree, 22'h3FFFFF, 32'hFFFFFFFF, 31'h0);
    send(CmdFree, 22'h3FFFFF, 32'hFFFFFFFF, 31'h0);
    send(CmdFree, 22'h0, 32'hFFFFFFFF, 31'h0);
    for (int c = CmdSched; c <= CmdUnlock; c++) send(4'(c), 22'h3FFFFF, 32'h0, 31'h0);
    send(4'd9, 22'h3FFFFF, 32'h0, 31'h0);
    send(4'd15, 22'h3FFFFF, 32'h0, 31'h0);
    send(CmdRemove, 22'h3FFFFF, 32'h0, 31'h0);
    send(CmdFree, 22'h3FFFFF, 32'h12345678, 31'h0);
    send(CmdRemove, 22'h0, 32'h0, 31'h0);
    live_allocs.delete();

    // id table overflow
    for (int i = 0; i < MaxProcs + 2; i++) send(CmdAdd, ids[i], 32'h0, 31'h0);
    for (int i = 2; i < MaxProcs; i += 3) send(CmdRemove, ids[i], 32'h0, 31'h0);

    for (int n = 0; n < 300; n++) begin
      if (n == 200) hold_req = 1'b1;
      random_beat();
    end
    mode = 1;
    for (int n = 0; n < 300; n++) random_beat();

    mode = 2;
    for (int n = 0; n < 180; n++) random_beat();
    send(CmdAdd, ids[5], 32'h0, 31'h0);
    send(CmdAlloc, ids[5], 32'hDEADBEEF, 31'h7FFFFFFF);
    send(CmdFree, ids[5], 32'hFFFFFFF0, 31'h0);
    send(CmdFree, ids[5], 32'hDEADBEEF, 31'h0);
    send(CmdRemove, ids[5], 32'h0, 31'h0);
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
    if (fails == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
